@@ sv/backlight_level_controller_assert.svh @@
// Assertion macros for the checker of the backlight level controller.
`ifndef BACKLIGHT_LEVEL_CONTROLLER_ASSERT_SVH
`define BACKLIGHT_LEVEL_CONTROLLER_ASSERT_SVH

// A property that must hold at every clock edge outside of reset.
`define BLLC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An implication whose consequent is checked after the antecedent, with the non-overlapping |=> operator.
`define BLLC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/bllc_pkg.sv @@
// Types, constants and register codes of the backlight level controller.
package bllc_pkg;

  localparam int LevelW    = 8;
  localparam int TimeoutW  = 16;
  localparam int TypeW     = 5;
  localparam int CodeW     = 10;
  localparam int ValueW    = 2;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 16;

  localparam logic OpEvent = 1'b0;
  localparam logic OpTick  = 1'b1;

  localparam logic [TypeW-1:0] EvTypeKey    = 5'd1;
  localparam logic [TypeW-1:0] EvTypeSwitch = 5'd5;

  localparam logic [CodeW-1:0] CodeIllumUp     = 10'd230;
  localparam logic [CodeW-1:0] CodeIllumDown   = 10'd229;
  localparam logic [CodeW-1:0] CodeIllumToggle = 10'd228;
  localparam logic [CodeW-1:0] CodeLid         = 10'd0;

  localparam logic [LevelW-1:0]   MaxLevelRst    = 8'd255;
  localparam logic [TimeoutW-1:0] IdleTimeoutRst = 16'd15;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMaxLevel    = 2'd0,
    CfgIdleTimeout = 2'd1,
    CfgLidEnable   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [LevelW-1:0]   max_level;
    logic [TimeoutW-1:0] idle_timeout;
    logic                lid_enable;
  } cfg_t;

  typedef struct packed {
    logic              operation;
    logic [TypeW-1:0]  event_type;
    logic [CodeW-1:0]  event_code;
    logic [ValueW-1:0] event_value;
  } in_item_t;

  typedef struct packed {
    logic [LevelW-1:0] level;
    logic              changed;
    logic [LevelW-1:0] remembered_level;
  } out_item_t;

endpackage

@@ sv/bllc_if.sv @@
// Handshake interfaces for the input, result and configuration channels.
interface bllc_in_if;
  import bllc_pkg::*;
  logic              valid;
  logic              ready;
  logic              operation;
  logic [TypeW-1:0]  event_type;
  logic [CodeW-1:0]  event_code;
  logic [ValueW-1:0] event_value;

  modport source (output valid, output operation, output event_type, output event_code,
                  output event_value, input ready);
  modport sink (input valid, input operation, input event_type, input event_code,
                input event_value, output ready);
endinterface

interface bllc_out_if;
  import bllc_pkg::*;
  logic              valid;
  logic              ready;
  logic [LevelW-1:0] level;
  logic              changed;
  logic [LevelW-1:0] remembered_level;

  modport source (output valid, output level, output changed, output remembered_level,
                  input ready);
  modport sink (input valid, input level, input changed, input remembered_level,
                output ready);
endinterface

interface bllc_cfg_if;
  import bllc_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/backlight_level_controller.sv @@
// Top level of the keyboard backlight level controller.
//
//   Channel  Direction  Carries
//   in_i     sink       operation, event_type, event_code, event_value
//   out_o    source     level, changed, remembered_level
//   cfg_i    sink       index, data (max_level, idle_timeout, lid_enable)
//
// An item is held in the input register and is evaluated against the state when it
// advances, which loads its result into the output register.
// A new item is accepted every cycle while the result is not stalled.
// Reset clears the level, the remembered level and the idle counter, and loads the
// register defaults. A stalled result holds the output register and backs up the
// input register; configuration writes are taken in every cycle.
module backlight_level_controller (
  input  logic       clk_i,
  input  logic       rst_ni,
  bllc_in_if.sink    in_i,
  bllc_out_if.source out_o,
  bllc_cfg_if.sink   cfg_i
);
  import bllc_pkg::*;

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_valid_q;
  out_item_t out_q, result;
  logic      out_valid_q;
  logic      advance;

  assign advance  = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q.operation   <= in_i.operation;
      in_q.event_type  <= in_i.event_type;
      in_q.event_code  <= in_i.event_code;
      in_q.event_value <= in_i.event_value;
    end
  end

  bllc_cfg u_cfg (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_i),
    .cfg_o (cfg)
  );

  bllc_step u_step (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .item_i  (in_q),
    .cfg_i   (cfg),
    .result_o(result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.level            = out_q.level;
  assign out_o.changed          = out_q.changed;
  assign out_o.remembered_level = out_q.remembered_level;
endmodule

@@ sv/bllc_cfg.sv @@
// Configuration register file of the backlight level controller.
module bllc_cfg (
  input  logic            clk_i,
  input  logic            rst_ni,
  bllc_cfg_if.sink        cfg_i,
  output bllc_pkg::cfg_t  cfg_o
);
  import bllc_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CfgMaxLevel:    cfg_d.max_level    = cfg_i.data[LevelW-1:0];
        CfgIdleTimeout: cfg_d.idle_timeout = cfg_i.data[TimeoutW-1:0];
        CfgLidEnable:   cfg_d.lid_enable   = cfg_i.data[0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_level    <= MaxLevelRst;
      cfg_q.idle_timeout <= IdleTimeoutRst;
      cfg_q.lid_enable   <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;
endmodule

@@ sv/bllc_step.sv @@
// Level, remembered level and idle counter with their update for one item.
module bllc_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  bllc_pkg::in_item_t  item_i,
  input  bllc_pkg::cfg_t      cfg_i,
  output bllc_pkg::out_item_t result_o
);
  import bllc_pkg::*;

  logic [LevelW-1:0]   applied_q, applied_d;
  logic [LevelW-1:0]   saved_q, saved_d;
  logic [TimeoutW-1:0] idle_q, idle_d;
  logic [TimeoutW:0]   idle_next;
  logic                key_press;
  logic                lid_event;

  assign key_press = (item_i.event_type == EvTypeKey) && (item_i.event_value != '0);
  assign lid_event = cfg_i.lid_enable && (item_i.event_type == EvTypeSwitch) &&
                     (item_i.event_code == CodeLid);
  assign idle_next = {1'b0, idle_q} + {{TimeoutW{1'b0}}, 1'b1};

  always_comb begin
    applied_d = applied_q;
    saved_d   = saved_q;
    idle_d    = idle_q;
    if (item_i.operation == OpEvent) begin
      idle_d = '0;
      if (key_press) begin
        case (item_i.event_code)
          CodeIllumUp: begin
            if (saved_q < cfg_i.max_level) saved_d = saved_q + 1'b1;
          end
          CodeIllumDown: begin
            if (saved_q != '0) saved_d = saved_q - 1'b1;
          end
          CodeIllumToggle: begin
            saved_d = (applied_q == '0) ? cfg_i.max_level : '0;
          end
          default: saved_d = saved_q;
        endcase
        applied_d = (saved_d > cfg_i.max_level) ? cfg_i.max_level : saved_d;
      end else if (lid_event) begin
        if (item_i.event_value != '0) begin
          if (applied_q != '0) saved_d = applied_q;
          applied_d = '0;
        end else begin
          applied_d = (saved_q > cfg_i.max_level) ? cfg_i.max_level : saved_q;
        end
      end
    end else begin
      // The counter reaching the timeout blanks the backlight like a lid close.
      if (idle_next >= {1'b0, cfg_i.idle_timeout}) begin
        if (applied_q != '0) saved_d = applied_q;
        applied_d = '0;
        idle_d    = '0;
      end else begin
        idle_d = idle_next[TimeoutW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      applied_q <= '0;
      saved_q   <= '0;
      idle_q    <= '0;
    end else if (step_i) begin
      applied_q <= applied_d;
      saved_q   <= saved_d;
      idle_q    <= idle_d;
    end
  end

  assign result_o.level            = applied_d;
  assign result_o.changed          = (applied_d != applied_q);
  assign result_o.remembered_level = saved_d;
endmodule

@@ sv/bllc_checker.sv @@
// Port-level assertions for the backlight level controller and their binding.
module bllc_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [bllc_pkg::LevelW-1:0] level_i,
  input logic                      changed_i,
  input logic [bllc_pkg::LevelW-1:0] remembered_level_i,
  input logic                      cfg_ready_i
);
  import bllc_pkg::*;
  `include "backlight_level_controller_assert.svh"

  logic              lit_ok;
  logic              out_stall;
  logic              in_take;
  logic [2*LevelW:0] out_bus;

  // A lit LED always shows the remembered level, possibly clamped down.
  assign lit_ok    = !out_valid_i || level_i == '0 || level_i <= remembered_level_i;
  assign out_stall = out_valid_i && !out_ready_i;
  assign in_take   = in_valid_i && in_ready_i;
  assign out_bus   = {level_i, changed_i, remembered_level_i};

  `BLLC_ASSERT(a_level_le_remembered, clk_i, rst_ni, lit_ok, "lit level exceeds remembered level")

  // Input backpressure only ever comes from a stalled result.
  `BLLC_ASSERT(a_ready_only_on_stall, clk_i, rst_ni, in_ready_i || out_stall, "needless input stall")

  `BLLC_ASSERT(a_cfg_always_ready, clk_i, rst_ni, cfg_ready_i, "configuration port not ready")

  `BLLC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_i && $stable(out_bus), "result changed")

  // An accepted item must be followed by a valid result on the output.
  `BLLC_ASSERT_NEXT(a_in_to_out, clk_i, rst_ni, in_take, ##1 out_valid_i, "item gave no result")
endmodule

bind backlight_level_controller bllc_checker u_bllc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .level_i           (out_o.level),
  .changed_i         (out_o.changed),
  .remembered_level_i(out_o.remembered_level),
  .cfg_ready_i       (cfg_i.ready)
);
